@@ rtl/dgsm_pkg.sv @@
// ----------------------------------------------------------------------------
// dgsm_pkg: shared types and constants for the depth grid sector minimum
// Field widths, register indexes, reset values and the queue entry format.
// ----------------------------------------------------------------------------
package dgsm_pkg;

  localparam int DEPTH_W           = 20;
  localparam int CFG_W             = 20;
  localparam int DIM_CFG_W         = 13;
  localparam int CFG_IDX_W         = 2;
  localparam int MAX_FRAME_DIM_DEF = 4096;

  localparam int NUM_BANDS   = 3;
  localparam int NUM_SECTORS = 3;
  localparam int CELL_W      = 4;
  localparam int BAND_W      = 2;

  // x/3 as (x * RECIP3) >> RECIP3_SHIFT, exact for x below 2**16
  localparam int RECIP3       = 43691;
  localparam int RECIP3_W     = 17;
  localparam int RECIP3_SHIFT = 17;

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam logic [DEPTH_W-1:0] NEAR_CUTOFF_RST = DEPTH_W'(200);
  localparam logic [DEPTH_W-1:0] NO_RETURN_RST   = DEPTH_W'(100000);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_CUTOFF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_RETURN    = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [BAND_W-1:0] LAST_BAND_IDX = BAND_W'(NUM_BANDS - 1);

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               hit;
    logic [CELL_W-1:0]  grid_idx;
    logic               start;
    logic               last;
  } entry_t;

endpackage

@@ rtl/dgsm_front.sv @@
// ----------------------------------------------------------------------------
// dgsm_front: raster position tracking and pixel classification
// Finds the band and sector of each pixel, applies the sampling and cutoff
// rules and pushes one entry per pixel into the queue.
// ----------------------------------------------------------------------------
module dgsm_front
  import dgsm_pkg::*;
#(
  parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(MAX_FRAME_DIM+1)-1:0]   width,
  input  logic [$clog2(MAX_FRAME_DIM+1)-1:0]   height,
  input  logic [$clog2(MAX_FRAME_DIM+1)-1:0]   band_size,
  input  logic [$clog2(MAX_FRAME_DIM+1)-1:0]   sector_size,
  input  logic [DEPTH_W-1:0]                   near_cutoff,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [DEPTH_W-1:0]                   in_depth_mm,
  input  logic                                 in_depth_invalid,
  input  logic                                 q_full,
  output logic                                 q_push,
  output entry_t                               q_entry
);

  localparam int POS_W = $clog2(MAX_FRAME_DIM);
  localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
  localparam int EXT_W = DIM_W + 1;

  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [BAND_W-1:0] band, sector;
  logic              row_even, col_even;
  logic              col_last, row_last;
  logic              accept;
  logic [EXT_W-1:0]  row_ext, col_ext, bs_ext, ss_ext;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept;

  assign row_ext = EXT_W'(row_r);
  assign col_ext = EXT_W'(col_r);
  assign bs_ext  = EXT_W'(band_size);
  assign ss_ext  = EXT_W'(sector_size);

  // a zero part size leaves everything in the last part
  always_comb begin
    priority if (row_ext < bs_ext) begin
      band = 2'd0;
    end else if (row_ext < (bs_ext << 1)) begin
      band = 2'd1;
    end else begin
      band = 2'd2;
    end
    priority if (col_ext < ss_ext) begin
      sector = 2'd0;
    end else if (col_ext < (ss_ext << 1)) begin
      sector = 2'd1;
    end else begin
      sector = 2'd2;
    end
  end

  // offset parity: only the middle part starts at an odd boundary
  assign row_even = ~(row_r[0] ^ ((band == 2'd1) & band_size[0]));
  assign col_even = ~(col_r[0] ^ ((sector == 2'd1) & sector_size[0]));

  assign col_last = (col_ext + EXT_W'(1)) >= EXT_W'(width);
  assign row_last = (row_ext + EXT_W'(1)) >= EXT_W'(height);

  always_comb begin
    q_entry.depth    = in_depth_mm;
    q_entry.hit      = row_even & col_even & ~in_depth_invalid & (in_depth_mm > near_cutoff);
    q_entry.grid_idx = CELL_W'({2'b00, band}) + CELL_W'({1'b0, band, 1'b0}) + CELL_W'(sector);
    q_entry.start    = (row_r == '0) & (col_r == '0);
    q_entry.last     = col_last & row_last;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (!col_last) begin
        col_nxt = col_r + POS_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

@@ rtl/dgsm_queue.sv @@
// ----------------------------------------------------------------------------
// dgsm_queue: short entry queue between front and back
// Small register queue so that the two sides can stall independently.
// ----------------------------------------------------------------------------
module dgsm_queue
  import dgsm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int CNT_W = QPTR_W + 1;

  entry_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/dgsm_back.sv @@
// ----------------------------------------------------------------------------
// dgsm_back: cell minimum update and result delivery
// Keeps the nine cell minima and the frame minimum, snapshots them at the
// end of a frame and hands out one band per transfer from an output register.
// ----------------------------------------------------------------------------
module dgsm_back
  import dgsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DEPTH_W-1:0]  no_return,
  input  logic                q_empty,
  input  entry_t              q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BAND_W-1:0]   out_band_index,
  output logic [DEPTH_W-1:0]  out_left_min,
  output logic [DEPTH_W-1:0]  out_center_min,
  output logic [DEPTH_W-1:0]  out_right_min,
  output logic [DEPTH_W-1:0]  out_band_min,
  output logic [DEPTH_W-1:0]  out_frame_min,
  output logic                out_last_band
);

  localparam int NUM_CELLS = NUM_BANDS * NUM_SECTORS;

  logic [DEPTH_W-1:0] cell_r   [NUM_CELLS];
  logic [DEPTH_W-1:0] cell_nxt [NUM_CELLS];
  logic [DEPTH_W-1:0] frame_r, frame_nxt;

  // snapshot rows shift up as each band is sent
  logic [DEPTH_W-1:0] bank_r [NUM_BANDS][NUM_SECTORS];
  logic [DEPTH_W-1:0] bank_frame_r;
  logic               bank_busy_r, bank_busy_nxt;
  logic [BAND_W-1:0]  bank_band_r, bank_band_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BAND_W-1:0]  band_idx_r;
  logic [DEPTH_W-1:0] left_r, center_r, right_r, band_min_r, frame_min_r;
  logic               last_band_r;

  logic               out_free, emit, load_bank;
  logic [DEPTH_W-1:0] lc_min, row_min, frame_base;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign emit      = bank_busy_r & out_free;
  assign q_pop     = ~q_empty & ~(q_head.last & bank_busy_r);
  assign load_bank = q_pop & q_head.last;

  always_comb begin
    logic [DEPTH_W-1:0] base;
    for (int i = 0; i < NUM_CELLS; i++) begin
      base = q_head.start ? no_return : cell_r[i];
      cell_nxt[i] = (q_head.hit && q_head.grid_idx == CELL_W'(i) && q_head.depth < base)
                    ? q_head.depth : base;
    end
    frame_base = q_head.start ? no_return : frame_r;
    frame_nxt  = (q_head.hit && q_head.depth < frame_base) ? q_head.depth : frame_base;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_bank) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        for (int s = 0; s < NUM_SECTORS; s++) begin
          bank_r[b][s] <= cell_nxt[b * NUM_SECTORS + s];
        end
      end
      bank_frame_r <= frame_nxt;
    end else if (emit) begin
      for (int b = 0; b < NUM_BANDS - 1; b++) begin
        for (int s = 0; s < NUM_SECTORS; s++) begin
          bank_r[b][s] <= bank_r[b + 1][s];
        end
      end
    end
  end

  always_comb begin
    bank_busy_nxt = bank_busy_r;
    bank_band_nxt = bank_band_r;
    if (load_bank) begin
      bank_busy_nxt = 1'b1;
      bank_band_nxt = '0;
    end else if (emit) begin
      bank_band_nxt = bank_band_r + BAND_W'(1);
      if (bank_band_r == LAST_BAND_IDX) begin
        bank_busy_nxt = 1'b0;
      end
    end
  end

  assign lc_min  = (bank_r[0][1] < bank_r[0][0]) ? bank_r[0][1] : bank_r[0][0];
  assign row_min = (bank_r[0][2] < lc_min) ? bank_r[0][2] : lc_min;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      band_idx_r  <= bank_band_r;
      left_r      <= bank_r[0][0];
      center_r    <= bank_r[0][1];
      right_r     <= bank_r[0][2];
      band_min_r  <= row_min;
      frame_min_r <= bank_frame_r;
      last_band_r <= (bank_band_r == LAST_BAND_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_busy_r <= 1'b0;
      bank_band_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bank_busy_r <= bank_busy_nxt;
      bank_band_r <= bank_band_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_band_index = band_idx_r;
  assign out_left_min   = left_r;
  assign out_center_min = center_r;
  assign out_right_min  = right_r;
  assign out_band_min   = band_min_r;
  assign out_frame_min  = frame_min_r;
  assign out_last_band  = last_band_r;

endmodule

@@ rtl/depth_grid_sector_min.sv @@
// ----------------------------------------------------------------------------
// depth_grid_sector_min: 3x3 grid minimum of a streamed depth frame
// Throughput is one pixel per cycle while the queue is not full, through the
// front, a four-entry queue and the back. The three band results of a frame
// leave on consecutive transfers.
// A frame of fewer than four pixels holds the input while its results drain.
// Synchronous active-low reset clears positions, queue and output valid and
// loads the registers with their defaults; the minima are reloaded per frame.
// ----------------------------------------------------------------------------
module depth_grid_sector_min
  import dgsm_pkg::*;
#(
  parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DEPTH_W-1:0]   in_depth_mm,
  input  logic                 in_depth_invalid,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BAND_W-1:0]    out_band_index,
  output logic [DEPTH_W-1:0]   out_left_min,
  output logic [DEPTH_W-1:0]   out_center_min,
  output logic [DEPTH_W-1:0]   out_right_min,
  output logic [DEPTH_W-1:0]   out_band_min,
  output logic [DEPTH_W-1:0]   out_frame_min,
  output logic                 out_last_band
);

  localparam int DIM_W  = $clog2(MAX_FRAME_DIM + 1);
  localparam int PROD_W = DIM_W + RECIP3_W;
  localparam int RST_W  = (FRAME_WIDTH_RST > MAX_FRAME_DIM) ? MAX_FRAME_DIM : FRAME_WIDTH_RST;
  localparam int RST_H  = (FRAME_HEIGHT_RST > MAX_FRAME_DIM) ? MAX_FRAME_DIM : FRAME_HEIGHT_RST;

  logic [DIM_W-1:0]     width_r, height_r, band_size_r, sector_size_r;
  logic [DEPTH_W-1:0]   near_cutoff_r, no_return_r;
  logic [DIM_CFG_W-1:0] wr_dim;
  logic [DIM_W-1:0]     wr_eff, wr_third;
  logic [PROD_W-1:0]    wr_prod;

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_push_entry, q_head;

  // clamp a written dimension and take a third of it once, at write time
  assign wr_dim = cfg_wdata[DIM_CFG_W-1:0];

  always_comb begin
    priority if (wr_dim == '0) begin
      wr_eff = DIM_W'(1);
    end else if (32'(wr_dim) > 32'(MAX_FRAME_DIM)) begin
      wr_eff = DIM_W'(MAX_FRAME_DIM);
    end else begin
      wr_eff = DIM_W'(wr_dim);
    end
  end

  assign wr_prod  = PROD_W'(wr_eff) * PROD_W'(RECIP3);
  assign wr_third = wr_prod[RECIP3_SHIFT +: DIM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= DIM_W'(RST_W);
      height_r      <= DIM_W'(RST_H);
      sector_size_r <= DIM_W'(RST_W / 3);
      band_size_r   <= DIM_W'(RST_H / 3);
      near_cutoff_r <= NEAR_CUTOFF_RST;
      no_return_r   <= NO_RETURN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_r       <= wr_eff;
          sector_size_r <= wr_third;
        end
        REG_FRAME_HEIGHT: begin
          height_r    <= wr_eff;
          band_size_r <= wr_third;
        end
        REG_NEAR_CUTOFF: begin
          near_cutoff_r <= cfg_wdata[DEPTH_W-1:0];
        end
        REG_NO_RETURN: begin
          no_return_r <= cfg_wdata[DEPTH_W-1:0];
        end
      endcase
    end
  end

  dgsm_front #(
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .width            (width_r),
    .height           (height_r),
    .band_size        (band_size_r),
    .sector_size      (sector_size_r),
    .near_cutoff      (near_cutoff_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_depth_mm      (in_depth_mm),
    .in_depth_invalid (in_depth_invalid),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_push_entry)
  );

  dgsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  dgsm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .no_return      (no_return_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_band_index (out_band_index),
    .out_left_min   (out_left_min),
    .out_center_min (out_center_min),
    .out_right_min  (out_right_min),
    .out_band_min   (out_band_min),
    .out_frame_min  (out_frame_min),
    .out_last_band  (out_last_band)
  );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: depth_grid_sector_min
// Streams depth frames of many shapes and thresholds through the block. A
// behavioural copy of the 3x3 grid predicts the three band results of each
// frame, and every result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dgsm_pkg::*;

  localparam int HOLD_CYCLES        = 300;
  localparam int SETTLE_CYCLES      = 8;
  localparam int RANDOM_ITEMS       = 180;
  localparam int MAX_SHOWN          = 10;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [DEPTH_W-1:0] lmin;
    logic [DEPTH_W-1:0] cmin;
    logic [DEPTH_W-1:0] rmin;
    logic [DEPTH_W-1:0] bmin;
    logic [DEPTH_W-1:0] fmin;
    logic               last_band;
  } band_result_t;

  logic                 clk;
  logic                 rst_n            = 1'b0;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_W-1:0]     cfg_wdata        = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [DEPTH_W-1:0]   in_depth_mm      = '0;
  logic                 in_depth_invalid = 1'b0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [BAND_W-1:0]    out_band_index;
  logic [DEPTH_W-1:0]   out_left_min;
  logic [DEPTH_W-1:0]   out_center_min;
  logic [DEPTH_W-1:0]   out_right_min;
  logic [DEPTH_W-1:0]   out_band_min;
  logic [DEPTH_W-1:0]   out_frame_min;
  logic                 out_last_band;

  // grid state and register copies as they stand after reset
  logic [DIM_CFG_W-1:0] frame_w        = 13'd640;
  logic [DIM_CFG_W-1:0] frame_h        = 13'd480;
  logic [DEPTH_W-1:0]   cutoff_mm      = 20'd200;
  logic [DEPTH_W-1:0]   no_return_mm   = 20'd100000;
  int unsigned          row_pos        = 0;
  int unsigned          col_pos        = 0;
  logic [DEPTH_W-1:0]   grid_min_mm [9] = '{default: 20'd100000};
  logic [DEPTH_W-1:0]   frame_min_mm   = 20'd100000;

  band_result_t pending_bands[$];
  band_result_t got_band;
  band_result_t want_band;
  int           fail_count    = 0;
  int           pixels_sent   = 0;
  bit           quiet         = 1'b0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;

  depth_grid_sector_min dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_depth_mm      (in_depth_mm),
    .in_depth_invalid (in_depth_invalid),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_band_index   (out_band_index),
    .out_left_min     (out_left_min),
    .out_center_min   (out_center_min),
    .out_right_min    (out_right_min),
    .out_band_min     (out_band_min),
    .out_frame_min    (out_frame_min),
    .out_last_band    (out_last_band)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned clamp_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_FRAME_DIM_DEF) return MAX_FRAME_DIM_DEF;
    return v;
  endfunction

  function automatic logic [1:0] grid_part(input int unsigned pos, input int unsigned size,
                                           output bit even_off);
    int unsigned idx;
    if (size == 0) begin
      idx = 2;
    end else begin
      idx = pos / size;
      if (idx > 2) idx = 2;
    end
    even_off = ((pos - idx * size) % 2) == 0;
    return 2'(idx);
  endfunction

  function automatic void accumulate_pixel(input logic [DEPTH_W-1:0] depth, input logic invalid);
    int unsigned  w;
    int unsigned  h;
    int unsigned  band;
    int unsigned  sector;
    bit           row_even;
    bit           col_even;
    band_result_t r;
    w = clamp_dim(frame_w);
    h = clamp_dim(frame_h);
    if (row_pos == 0 && col_pos == 0) begin
      foreach (grid_min_mm[i]) grid_min_mm[i] = no_return_mm;
      frame_min_mm = no_return_mm;
    end
    band   = grid_part(row_pos, h / 3, row_even);
    sector = grid_part(col_pos, w / 3, col_even);
    if (row_even && col_even && !invalid && depth > cutoff_mm) begin
      if (depth < grid_min_mm[band * 3 + sector]) grid_min_mm[band * 3 + sector] = depth;
      if (depth < frame_min_mm) frame_min_mm = depth;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    if (row_pos + 1 < h) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    for (int k = 0; k < 3; k++) begin
      r.band      = BAND_W'(k);
      r.lmin      = grid_min_mm[k * 3];
      r.cmin      = grid_min_mm[k * 3 + 1];
      r.rmin      = grid_min_mm[k * 3 + 2];
      r.bmin      = r.lmin;
      if (r.cmin < r.bmin) r.bmin = r.cmin;
      if (r.rmin < r.bmin) r.bmin = r.rmin;
      r.fmin      = frame_min_mm;
      r.last_band = (k == 2);
      pending_bands.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string show(input band_result_t r);
    return $sformatf("band %0d left %0d centre %0d right %0d band_min %0d frame_min %0d last %0d",
                     r.band, r.lmin, r.cmin, r.rmin, r.bmin, r.fmin, r.last_band);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_band.band      = out_band_index;
      got_band.lmin      = out_left_min;
      got_band.cmin      = out_center_min;
      got_band.rmin      = out_right_min;
      got_band.bmin      = out_band_min;
      got_band.fmin      = out_frame_min;
      got_band.last_band = out_last_band;
      if (pending_bands.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("unexpected result transfer: %s", show(got_band));
      end else begin
        want_band = pending_bands.pop_front();
        if (got_band !== want_band) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want_band));
            $display("  actual   %s", show(got_band));
          end
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic invalid);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 10) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_depth_mm      <= depth;
    in_depth_invalid <= invalid;
    do @(posedge clk); while (in_stall !== 1'b0);
    accumulate_pixel(depth, invalid);
    pixels_sent++;
  endtask

  // wait for every predicted band, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  frame_w      = value[DIM_CFG_W-1:0];
      REG_FRAME_HEIGHT: frame_h      = value[DIM_CFG_W-1:0];
      REG_NEAR_CUTOFF:  cutoff_mm    = value[DEPTH_W-1:0];
      REG_NO_RETURN:    no_return_mm = value[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  // depths clustered round the cutoff and the no-return value
  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(5))
      0:       return DEPTH_W'($urandom);
      1:       return cutoff_mm + DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
      2:       return DEPTH_W'($urandom_range(0, 1023));
      3:       return no_return_mm + DEPTH_W'($urandom_range(0, 4)) - DEPTH_W'(2);
      default: return cutoff_mm + DEPTH_W'($urandom_range(1, 5000));
    endcase
  endfunction

  // keeps sending until the grid wraps back to the first pixel
  task automatic send_frame();
    do send_pixel(pick_depth(), $urandom_range(9) == 0);
    while (row_pos != 0 || col_pos != 0);
  endtask

  function automatic logic [CFG_W-1:0] random_dim();
    logic [DIM_CFG_W-1:0] d;
    case ($urandom_range(9))
      0:       d = DIM_CFG_W'($urandom_range(0, 2));
      9:       d = DIM_CFG_W'($urandom_range(10, 16));
      default: d = DIM_CFG_W'($urandom_range(3, 9));
    endcase
    return {(CFG_W - DIM_CFG_W)'($urandom), d};
  endfunction

  // ---------------------------------------------------------------- tests

  // cutoff and no-return value straight out of reset, one pixel per cell
  task automatic test_default_thresholds();
    logic [DEPTH_W-1:0] depths [9];
    depths = '{20'd200, 20'd201, 20'd5, 20'd100000, 20'd100001,
               20'd250, 20'd199, 20'd0, 20'd300};
    write_reg(REG_FRAME_WIDTH, 20'd3);
    write_reg(REG_FRAME_HEIGHT, 20'd3);
    foreach (depths[i]) send_pixel(depths[i], i == 2 || i == 8);
    settle();
  endtask

  task automatic test_field_extremes();
    logic [DEPTH_W-1:0] depths [9];
    depths = '{20'd0, 20'd1, 20'hFFFFF, 20'hFFFFE, 20'd3,
               20'd0, 20'hFFFFF, 20'd2, 20'd1};
    write_reg(REG_NEAR_CUTOFF, 20'd0);
    write_reg(REG_NO_RETURN, 20'hFFFFF);
    foreach (depths[i]) send_pixel(depths[i], i == 4);
    settle();
    // nothing can pass a full-scale cutoff, so every cell reports zero
    write_reg(REG_NEAR_CUTOFF, 20'hFFFFF);
    write_reg(REG_NO_RETURN, 20'd0);
    write_reg(REG_FRAME_HEIGHT, 20'd1);
    send_pixel(20'hFFFFF, 1'b0);
    send_pixel(20'd0, 1'b0);
    send_pixel(20'hFFFFF, 1'b1);
    settle();
  endtask

  // zero sizes act as one; under three rows or columns all goes to the last part
  task automatic test_small_frames();
    write_reg(REG_NEAR_CUTOFF, 20'd10);
    write_reg(REG_NO_RETURN, 20'd50000);
    write_reg(REG_FRAME_WIDTH, 20'd0);
    write_reg(REG_FRAME_HEIGHT, 20'd0);
    send_frame();
    send_frame();
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd2);
    write_reg(REG_FRAME_HEIGHT, 20'd2);
    send_frame();
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd1);
    write_reg(REG_FRAME_HEIGHT, 20'd4);
    send_frame();
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd4);
    write_reg(REG_FRAME_HEIGHT, 20'd1);
    send_frame();
    settle();
  endtask

  // shrink the frame under the current position, and move the no-return value
  task automatic test_midframe_changes();
    write_reg(REG_FRAME_WIDTH, 20'd6);
    write_reg(REG_FRAME_HEIGHT, 20'd6);
    repeat (14) send_pixel(pick_depth(), 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd2);
    repeat (3) send_pixel(pick_depth(), 1'b0);
    settle();
    write_reg(REG_NO_RETURN, 20'd777);
    write_reg(REG_FRAME_HEIGHT, 20'd2);
    send_frame();
    send_frame();
    settle();
  endtask

  // register values beyond the largest frame size are clamped; a short
  // stretch of the long row or column is sent, then a resize closes the frame
  task automatic test_dim_limits();
    write_reg(REG_NEAR_CUTOFF, 20'd300);
    write_reg(REG_NO_RETURN, 20'd90000);
    write_reg(REG_FRAME_WIDTH, 20'hFFFFF);
    write_reg(REG_FRAME_HEIGHT, 20'd1);
    repeat (12) send_pixel(pick_depth(), 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd2);
    send_frame();
    settle();
    write_reg(REG_FRAME_WIDTH, 20'd1);
    write_reg(REG_FRAME_HEIGHT, 20'd8191);
    repeat (12) send_pixel(pick_depth(), 1'b0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 20'd2);
    send_frame();
    settle();
  endtask

  // results back up behind a long receiver hold-off until the input stalls
  task automatic test_backpressure();
    write_reg(REG_FRAME_WIDTH, 20'd2);
    write_reg(REG_FRAME_HEIGHT, 20'd1);
    hold_req = 1'b1;
    repeat (20) send_frame();
    settle();
  endtask

  task automatic test_random_frames();
    int first_item;
    first_item = pixels_sent;
    quiet = 1'b1;
    while (pixels_sent - first_item < RANDOM_ITEMS) begin
      if (pixels_sent - first_item > 80) quiet = 1'b0;
      settle();
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_WIDTH, random_dim());
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_HEIGHT, random_dim());
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0:       write_reg(REG_NEAR_CUTOFF, 20'd0);
          1:       write_reg(REG_NEAR_CUTOFF, CFG_W'($urandom));
          default: write_reg(REG_NEAR_CUTOFF, CFG_W'($urandom_range(0, 600)));
        endcase
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(5))
          0:       write_reg(REG_NO_RETURN, 20'd0);
          1:       write_reg(REG_NO_RETURN, 20'hFFFFF);
          default: write_reg(REG_NO_RETURN, CFG_W'($urandom_range(500, 200000)));
        endcase
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(7) == 0) begin
          // broken frame: a resize lands part way through
          repeat ($urandom_range(1, 10)) send_pixel(pick_depth(), $urandom_range(9) == 0);
          settle();
          if ($urandom_range(1) == 0) write_reg(REG_FRAME_WIDTH, random_dim());
          else write_reg(REG_FRAME_HEIGHT, random_dim());
        end
        send_frame();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_thresholds();
    test_field_extremes();
    test_small_frames();
    test_midframe_changes();
    test_dim_limits();
    test_backpressure();
    test_random_frames();
    settle();
    if (fail_count == 0 && pending_bands.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
